// ----- design/ssr_pkg.sv -----
// Shared types and constants for the soft-start reference ramp.
// No dependencies; imported by every module of the block.
`default_nettype none

package ssr_pkg;

  // widths of the reference path, the fraction accumulator and the command code
  localparam int unsigned REF_W  = 16;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned CMD_W  = 3;

  // configuration port
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_RAMP_STEP = 3'd0;
  localparam logic [FRAC_W-1:0] RAMP_STEP_RESET = 16'd256;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_LOAD    = 3'd1,
    CMD_TARGET  = 3'd2,
    CMD_ENABLE  = 3'd3,
    CMD_DISABLE = 3'd4
  } cmd_t;

  // one input beat
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic signed [REF_W-1:0] value;
  } item_t;

  // one result beat
  typedef struct packed {
    logic signed [REF_W-1:0] reference;
    logic                    active;
  } result_t;

endpackage

`default_nettype wire

// ----- design/ssr_cfg.sv -----
// APB-style configuration register holding the ramp step size.
// Depends on ssr_pkg.
`default_nettype none

module ssr_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ssr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [ssr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [ssr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output logic      [ssr_pkg::FRAC_W-1:0]      ramp_step
);
  import ssr_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr == ADDR_RAMP_STEP);

  // step register
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step <= RAMP_STEP_RESET;
    end else if (wr_en) begin
      ramp_step <= pwdata[FRAC_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_RAMP_STEP) begin
      prdata = {{(CFG_DATA_W-FRAC_W){1'b0}}, ramp_step};
    end
  end

endmodule

`default_nettype wire

// ----- design/ssr_core.sv -----
// Ramp state and the single-pass command datapath: accumulator add,
// delta times fraction product and reference sum. Depends on ssr_pkg.
`default_nettype none

module ssr_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       advance,
  input  wire ssr_pkg::item_t             item,
  input  wire logic [ssr_pkg::FRAC_W-1:0] ramp_step,
  output ssr_pkg::result_t                result
);
  import ssr_pkg::*;

  // state
  logic signed [REF_W-1:0] current_reference, current_reference_next;
  logic signed [REF_W-1:0] start_reference, start_reference_next;
  logic signed [REF_W-1:0] target_reference, target_reference_next;
  logic signed [REF_W-1:0] ramp_delta, ramp_delta_next;
  logic        [FRAC_W-1:0] ramp_fraction, ramp_fraction_next;
  logic                     ramp_active, ramp_active_next;

  // datapath
  logic [FRAC_W-1:0]             frac_inc;
  logic [FRAC_W:0]               frac_probe;
  logic                          ramp_done;
  logic signed [REF_W+FRAC_W:0]  prod;
  logic signed [REF_W-1:0]       ramp_point;

  // fraction step and end test: next add would carry out
  assign frac_inc   = ramp_fraction + ramp_step;
  assign frac_probe = {1'b0, frac_inc} + {1'b0, ramp_step};
  assign ramp_done  = frac_probe[FRAC_W];

  // signed delta times unsigned fraction, floor shift, wrap
  assign prod       = ramp_delta * $signed({1'b0, frac_inc});
  assign ramp_point = start_reference + prod[REF_W+FRAC_W-1:FRAC_W];

  // command decode
  always_comb begin
    current_reference_next = current_reference;
    start_reference_next   = start_reference;
    target_reference_next  = target_reference;
    ramp_delta_next        = ramp_delta;
    ramp_fraction_next     = ramp_fraction;
    ramp_active_next       = ramp_active;
    case (cmd_t'(item.command))
      CMD_TICK: begin
        if (ramp_active) begin
          ramp_fraction_next = frac_inc;
          if (ramp_done) begin
            current_reference_next = target_reference;
            ramp_active_next       = 1'b0;
          end else begin
            current_reference_next = ramp_point;
          end
        end
      end
      CMD_LOAD: begin
        current_reference_next = item.value;
        start_reference_next   = item.value;
        ramp_active_next       = 1'b0;
      end
      CMD_TARGET: begin
        target_reference_next = item.value;
        ramp_delta_next       = item.value - current_reference;
        start_reference_next  = current_reference;
        ramp_fraction_next    = '0;
      end
      CMD_ENABLE: ramp_active_next = 1'b1;
      CMD_DISABLE: ramp_active_next = 1'b0;
      default: ;
    endcase
  end

  assign result.reference = current_reference_next;
  assign result.active    = ramp_active_next;

  // state update on each processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      current_reference <= '0;
      start_reference   <= '0;
      target_reference  <= '0;
      ramp_delta        <= '0;
      ramp_fraction     <= '0;
      ramp_active       <= 1'b0;
    end else if (advance) begin
      current_reference <= current_reference_next;
      start_reference   <= start_reference_next;
      target_reference  <= target_reference_next;
      ramp_delta        <= ramp_delta_next;
      ramp_fraction     <= ramp_fraction_next;
      ramp_active       <= ramp_active_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/soft_start_reference_ramp.sv -----
// Soft-start reference ramp top level: input register, ramp core, result
// register and configuration port. Depends on ssr_pkg, ssr_cfg, ssr_core.
//
// Usage:
//   Commands enter on the input channel (in_valid, in_stall, command, value);
//   each command gives exactly one result beat on the output channel
//   (out_valid, out_stall, reference, active).
//   An accepted beat is held in the input register while the core computes,
//   and its result is loaded into the result register, which drives out_valid;
//   a stall on the output channel can hold the beat in the input register.
//   Throughput is one command per cycle while the receiver does not stall;
//   the core's state update (fraction add, 16x16 product, reference add) is
//   registered in the same cycle the beat enters the result register.
//   When the receiver stalls, the result register holds its beat and the
//   input register keeps one more; in_stall rises once both are full.
//   The step size is written through the APB port at byte address 0; the user
//   must do so only while the block is idle, as the block does not enforce it.
//   Reset clears the ramp state to zero, sets the step to 256 and empties
//   both registers; no clearing pass is needed.
`default_nettype none

module soft_start_reference_ramp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // command channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ssr_pkg::CMD_W-1:0]       command,
  input  wire logic signed [ssr_pkg::REF_W-1:0] value,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [ssr_pkg::REF_W-1:0]     reference,
  output logic                                 active,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ssr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [ssr_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [ssr_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready
);
  import ssr_pkg::*;

  logic              in_reg_valid;
  item_t             in_item;
  logic              advance;
  logic              in_accept;
  logic [FRAC_W-1:0] ramp_step;
  result_t           core_result;
  result_t           out_result;

  ssr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .ramp_step (ramp_step)
  );

  ssr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (in_item),
    .ramp_step (ramp_step),
    .result    (core_result)
  );

  // handshake
  assign advance   = in_reg_valid & (~out_valid | ~out_stall);
  assign in_stall  = in_reg_valid & ~advance;
  assign in_accept = in_valid & ~in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else begin
      in_reg_valid <= in_accept | (in_reg_valid & ~advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item.command <= command;
      in_item.value   <= value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign reference = out_result.reference;
  assign active    = out_result.active;

endmodule

`default_nettype wire

// ----- bench/tb_soft_start_reference_ramp.sv -----
// Self-checking bench for soft_start_reference_ramp: drives command beats and
// step writes, predicts every result beat and compares it field by field.
// Depends on ssr_pkg and the soft_start_reference_ramp top level.
`timescale 1ns / 1ps

// expected reference and active flag for every accepted command
class ramp_scoreboard;
  ssr_pkg::result_t expected_q[$];
  logic [15:0] step_size;
  logic [15:0] cur_ref;
  logic [15:0] start_ref;
  logic [15:0] target_ref;
  logic [15:0] delta;
  logic [15:0] fraction;
  logic        running;
  int          errors;
  int          beats_checked;

  function new();
    step_size     = ssr_pkg::RAMP_STEP_RESET;
    cur_ref       = '0;
    start_ref     = '0;
    target_ref    = '0;
    delta         = '0;
    fraction      = '0;
    running       = 1'b0;
    errors        = 0;
    beats_checked = 0;
  endfunction

  function void set_step(logic [15:0] s);
    step_size = s;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void report(string msg);
    errors++;
    if (errors <= 40)
      $display("mismatch at result beat %0d: %s", beats_checked, msg);
  endfunction

  // advance the ramp state by one accepted command
  function void note_command(logic [2:0] cmd, logic [15:0] val);
    longint product;
    longint scaled;
    ssr_pkg::result_t r;
    case (cmd)
      ssr_pkg::CMD_TICK: begin
        if (running) begin
          fraction = fraction + step_size;
          product  = longint'($signed(delta)) * longint'(fraction);
          // arithmetic shift gives the floor for negative products
          scaled   = product >>> 16;
          cur_ref  = start_ref + scaled[15:0];
          if ((int'(16'hffff) - int'(fraction)) < int'(step_size)) begin
            cur_ref = target_ref;
            running = 1'b0;
          end
        end
      end
      ssr_pkg::CMD_LOAD: begin
        cur_ref   = val;
        start_ref = val;
        running   = 1'b0;
      end
      ssr_pkg::CMD_TARGET: begin
        target_ref = val;
        delta      = val - cur_ref;
        start_ref  = cur_ref;
        fraction   = '0;
      end
      ssr_pkg::CMD_ENABLE:  running = 1'b1;
      ssr_pkg::CMD_DISABLE: running = 1'b0;
      default: ;
    endcase
    r.reference = cur_ref;
    r.active    = running;
    expected_q.push_back(r);
  endfunction

  // compare one result beat with the oldest expectation
  function void check_result(logic [15:0] got_ref, logic got_active);
    ssr_pkg::result_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected beat reference=%0d active=%0b",
                       $signed(got_ref), got_active));
    end else begin
      want = expected_q.pop_front();
      if (got_ref !== want.reference)
        report($sformatf("reference got %0d want %0d",
                         $signed(got_ref), $signed(want.reference)));
      if (got_active !== want.active)
        report($sformatf("active got %0b want %0b", got_active, want.active));
    end
    beats_checked++;
  endfunction
endclass

module tb_soft_start_reference_ramp;

  // command codes the block ignores
  localparam logic [2:0] CMD_UNUSED_5 = 3'd5;
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  localparam int PHASE_ITEMS = 200;
  localparam int CYCLE_LIMIT = 600000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [2:0]  command   = '0;
  logic [15:0] value     = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] reference;
  logic        active;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [ssr_pkg::CFG_ADDR_W-1:0] paddr  = '0;
  logic [ssr_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [ssr_pkg::CFG_DATA_W-1:0] prdata;
  logic        pready;

  ramp_scoreboard sb = new();
  int          sent_items = 0;
  int          cycles = 0;
  logic [15:0] cur_step = ssr_pkg::RAMP_STEP_RESET;
  bit          sender_calm = 1'b0;

  soft_start_reference_ramp dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .reference(reference),
    .active(active),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // accepted command beats feed the predictor
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_command(command, value);
  end

  // accepted result beats are checked
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(reference, active);
  end

  // receiver: random stall before each beat, with calm stretches
  initial begin : receiver
    int hold;
    int run_len;
    bit calm;
    run_len = 0;
    calm = 1'b0;
    @(posedge clk);
    forever begin
      if (run_len == 0) begin
        run_len = $urandom_range(1, 40);
        calm = ($urandom_range(0, 2) == 0);
      end
      hold = calm ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      run_len--;
    end
  end

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 11))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // one command beat; returns right after the accepting edge
  task automatic send_beat(logic [2:0] cmd, logic [15:0] val);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  // wait until every expected beat is back, then let the pipeline settle;
  // the first edge lets the monitor note a beat accepted at the last edge
  task automatic wait_idle();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // APB write of the step register, setup then access
  task automatic write_step(logic [15:0] s);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ssr_pkg::ADDR_RAMP_STEP;
    pwdata  <= {16'($urandom_range(0, 65535)), s};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_step(s);
    cur_step = s;
  endtask

  // load (usually), target, enable (usually) and a run of ticks, with some noise mixed in
  task automatic ramp_sequence();
    int tick_cap;
    int n_ticks;
    sender_calm = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 4) != 0)
      send_beat(ssr_pkg::CMD_LOAD, rand_value());
    send_beat(ssr_pkg::CMD_TARGET, rand_value());
    if ($urandom_range(0, 9) != 0)
      send_beat(ssr_pkg::CMD_ENABLE, rand_value());
    tick_cap = (cur_step == 0) ? 40 : 65536 / int'(cur_step) + 3;
    if (tick_cap > 80)
      tick_cap = 80;
    n_ticks = $urandom_range(1, tick_cap);
    for (int i = 0; i < n_ticks; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_beat(3'($urandom_range(1, 7)), rand_value());
      send_beat(ssr_pkg::CMD_TICK, rand_value());
    end
  endtask

  initial begin : stimulus
    logic [15:0] step_plan[$];
    int phase_end;
    step_plan = '{16'd4096, 16'hffff, 16'd0, 16'd1, 16'h8000, 16'hfffe,
                  16'($urandom_range(1000, 20000)), 16'($urandom_range(0, 65535)),
                  ssr_pkg::RAMP_STEP_RESET};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset step, idle tick, unused codes, value extremes
    send_beat(ssr_pkg::CMD_TICK, 16'h1234);
    send_beat(CMD_UNUSED_5, 16'h7fff);
    send_beat(CMD_UNUSED_6, 16'h8000);
    send_beat(CMD_UNUSED_7, 16'hffff);
    // enable with no target set: ramp runs on held state
    send_beat(ssr_pkg::CMD_ENABLE, 16'h0000);
    send_beat(ssr_pkg::CMD_TICK, 16'h0000);
    send_beat(ssr_pkg::CMD_TICK, 16'hffff);
    send_beat(ssr_pkg::CMD_DISABLE, 16'h5555);
    // wrapping delta from max to min
    send_beat(ssr_pkg::CMD_LOAD, 16'h7fff);
    send_beat(ssr_pkg::CMD_TARGET, 16'h8000);
    send_beat(ssr_pkg::CMD_ENABLE, 16'haaaa);
    send_beat(ssr_pkg::CMD_TICK, 16'h0000);
    send_beat(ssr_pkg::CMD_TICK, 16'h0000);
    // load while active clears the flag
    send_beat(ssr_pkg::CMD_LOAD, 16'h8000);
    send_beat(ssr_pkg::CMD_TARGET, 16'h7fff);
    send_beat(ssr_pkg::CMD_ENABLE, 16'h0000);
    send_beat(ssr_pkg::CMD_TICK, 16'h0000);
    send_beat(ssr_pkg::CMD_TICK, 16'h0000);
    // retarget mid-ramp, delta wraps to a positive value
    send_beat(ssr_pkg::CMD_TARGET, 16'hff00);
    send_beat(ssr_pkg::CMD_TICK, 16'h0000);
    send_beat(ssr_pkg::CMD_TICK, 16'h0000);
    send_beat(ssr_pkg::CMD_DISABLE, 16'h0000);
    send_beat(ssr_pkg::CMD_TICK, 16'h0000);
    in_valid <= 1'b0;

    // random phases, one step setting each
    foreach (step_plan[p]) begin
      wait_idle();
      write_step(step_plan[p]);
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end)
        ramp_sequence();
      in_valid <= 1'b0;
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
design/ssr_pkg.sv
design/ssr_cfg.sv
design/ssr_core.sv
design/soft_start_reference_ramp.sv
bench/tb_soft_start_reference_ramp.sv
